### hw/rtl/pclw_pkg.sv
// Shared types, constants and helper functions for the PCI capability list walker.
package pclw_pkg;

    // Walk limits and pointer window
    localparam int unsigned MAX_STEPS   = 48;
    localparam logic [7:0]  CAP_LO      = 8'h40;
    localparam logic [7:0]  CAP_HI      = 8'hfc;
    localparam logic [7:0]  PTR_MASK    = 8'hfc;
    localparam logic [7:0]  LAYOUT_MASK = 8'h7f;
    localparam int unsigned CAP_LIST_BIT = 4;

    // One visited bit per dword in the capability window
    localparam int unsigned MAP_BITS = (int'(CAP_HI) - int'(CAP_LO)) / 4 + 1;
    localparam int unsigned MAP_IDX_W = $clog2(MAP_BITS);
    localparam int unsigned COUNT_W = 7;

    // Command codes
    typedef enum logic [0:0] {
        CMD_BEGIN  = 1'b0,
        CMD_HEADER = 1'b1
    } cmd_t;

    // Access outcome codes
    typedef enum logic [1:0] {
        ACC_FINE   = 2'd0,
        ACC_INVAL  = 2'd1,
        ACC_CTX    = 2'd2,
        ACC_RSVD   = 2'd3
    } access_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_INVAL   = 3'd1,
        ST_CTX     = 3'd2,
        ST_NODEV   = 3'd3,
        ST_BADLIST = 3'd4
    } status_t;

    // Header layout codes that carry a capability pointer
    localparam logic [7:0] LAYOUT_TYPE0 = 8'd0;
    localparam logic [7:0] LAYOUT_TYPE1 = 8'd1;

    localparam logic [15:0] VENDOR_ABSENT = 16'hffff;

    typedef struct packed {
        logic [0:0]  cmd;
        logic [1:0]  access_error;
        logic [15:0] vendor_word;
        logic [15:0] status_word;
        logic [7:0]  htype_byte;
        logic [7:0]  cap_pointer;
        logic [7:0]  capacity;
        logic [15:0] cap_hdr;
    } req_item_t;

    typedef struct packed {
        logic [7:0]         read_offset;
        logic [7:0]         cap_id;
        logic [7:0]         cap_offset;
        logic               recorded;
        logic [COUNT_W-1:0] found_count;
        logic               done_res;
        logic [2:0]         result_status;
    } rsp_item_t;

    // Visited-map bit for a dword-aligned pointer inside the window
    function automatic logic [MAP_IDX_W-1:0] map_index(input logic [7:0] p);
        logic [7:0] rel;
        rel = p - CAP_LO;
        return rel[MAP_IDX_W+1:2];
    endfunction

    // Access error to status; the reserved code reads as invalid argument
    function automatic status_t map_error(input logic [1:0] e);
        return (e == ACC_CTX) ? ST_CTX : ST_INVAL;
    endfunction

endpackage

### hw/rtl/pclw_req_if.sv
// Request channel: valid/ready handshake carrying one walker input item.
interface pclw_req_if;
    logic               valid;
    logic               ready;
    pclw_pkg::req_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

### hw/rtl/pclw_rsp_if.sv
// Response channel: valid/ready handshake carrying one walker result item.
interface pclw_rsp_if;
    logic               valid;
    logic               ready;
    pclw_pkg::rsp_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

### hw/rtl/pci_capability_list_walker_unit.sv
// Top level of the PCI capability list walker: walk state, result logic, output buffer.
//
//   channel | dir | modport | payload
//   req     | in  | sink    | cmd, access_error, vendor_word, status_word, htype_byte,
//           |     |         | cap_pointer, capacity, cap_hdr
//   rsp     | out | source  | read_offset, cap_id, cap_offset, recorded, found_count,
//           |     |         | done_res, result_status
//
// One item per cycle while req.ready is high; results go to out_reg, or to the
// skid while out_reg is held. Walk state and the 48-bit visited map update in
// the cycle the item is taken. rst_n clears the walk state and empties the
// output buffer. A two-entry buffer (output register plus skid) keeps req.ready
// high while out_reg alone is held; req.ready drops only while the skid is full.
module pci_capability_list_walker_unit (
    input  logic        clk,
    input  logic        rst_n,
    pclw_req_if.sink    req,
    pclw_rsp_if.source  rsp
);

    // Walk state
    logic                            walking_reg, walking_next;
    logic [7:0]                      cur_ptr_reg, cur_ptr_next;
    logic [pclw_pkg::MAP_BITS-1:0]   visited_reg, visited_next;
    logic [pclw_pkg::COUNT_W-1:0]    found_reg, found_next;
    logic [7:0]                      limit_reg, limit_next;

    // Output buffer
    pclw_pkg::rsp_item_t out_reg, skid_reg, res;
    logic                out_valid_reg, skid_valid_reg;

    logic accept;
    logic taken;

    assign req.ready = !skid_valid_reg;
    assign accept    = req.valid && req.ready;
    assign taken     = out_valid_reg && rsp.ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.item  = out_reg;

    // Result and next walk state for the presented item
    always_comb
    begin
        pclw_pkg::req_item_t             it;
        logic [7:0]                      ptr;
        logic [pclw_pkg::MAP_BITS-1:0]   map_base;
        logic [pclw_pkg::COUNT_W-1:0]    cnt;
        logic [7:0]                      layout;
        logic                            follow;
        logic                            in_range;
        logic                            seen;
        logic [pclw_pkg::MAP_IDX_W-1:0]  idx;

        it           = req.item;
        walking_next = walking_reg;
        cur_ptr_next = cur_ptr_reg;
        visited_next = visited_reg;
        found_next   = found_reg;
        limit_next   = limit_reg;
        res          = '0;
        follow       = 1'b0;
        ptr          = '0;
        map_base     = visited_reg;
        cnt          = found_reg;
        layout       = it.htype_byte & pclw_pkg::LAYOUT_MASK;

        if (it.cmd == pclw_pkg::CMD_BEGIN)
        begin
            // Begin: fresh walk, then the probe checks in priority order
            walking_next = 1'b0;
            cur_ptr_next = '0;
            visited_next = '0;
            found_next   = '0;
            limit_next   = it.capacity;
            map_base     = '0;
            cnt          = '0;
            if (it.access_error != pclw_pkg::ACC_FINE)
            begin
                res.done_res      = 1'b1;
                res.result_status = pclw_pkg::map_error(it.access_error);
            end
            else if (it.vendor_word == pclw_pkg::VENDOR_ABSENT)
            begin
                res.done_res      = 1'b1;
                res.result_status = pclw_pkg::ST_NODEV;
            end
            else if (!it.status_word[pclw_pkg::CAP_LIST_BIT] ||
                     (layout != pclw_pkg::LAYOUT_TYPE0 && layout != pclw_pkg::LAYOUT_TYPE1))
            begin
                res.done_res      = 1'b1;
                res.result_status = pclw_pkg::ST_OK;
            end
            else
            begin
                follow = 1'b1;
                ptr    = it.cap_pointer & pclw_pkg::PTR_MASK;
            end
        end
        else if (!walking_reg)
        begin
            // Header with no walk running: state untouched
            res.done_res      = 1'b1;
            res.result_status = pclw_pkg::ST_INVAL;
        end
        else if (it.access_error != pclw_pkg::ACC_FINE)
        begin
            walking_next      = 1'b0;
            res.done_res      = 1'b1;
            res.result_status = pclw_pkg::map_error(it.access_error);
        end
        else
        begin
            // Count this capability, then follow its next pointer
            res.cap_id     = it.cap_hdr[7:0];
            res.cap_offset = cur_ptr_reg;
            res.recorded   = ({1'b0, found_reg} < {1'b0, limit_reg});
            cnt            = found_reg + 1'b1;
            found_next     = cnt;
            follow         = 1'b1;
            ptr            = it.cap_hdr[15:8] & pclw_pkg::PTR_MASK;
        end

        // Advance: end on null, bad, repeated pointer or step limit
        in_range = (ptr >= pclw_pkg::CAP_LO) && (ptr <= pclw_pkg::CAP_HI);
        idx      = pclw_pkg::map_index(ptr);
        seen     = 1'b0;
        if (in_range)
        begin
            seen = map_base[idx];
        end
        if (follow)
        begin
            if (ptr == 8'd0)
            begin
                walking_next      = 1'b0;
                res.done_res      = 1'b1;
                res.result_status = pclw_pkg::ST_OK;
            end
            else if (cnt >= pclw_pkg::COUNT_W'(pclw_pkg::MAX_STEPS) || !in_range || seen)
            begin
                walking_next      = 1'b0;
                res.done_res      = 1'b1;
                res.result_status = pclw_pkg::ST_BADLIST;
            end
            else
            begin
                walking_next      = 1'b1;
                cur_ptr_next      = ptr;
                visited_next      = map_base;
                visited_next[idx] = 1'b1;
                res.read_offset   = ptr;
            end
        end
        res.found_count = cnt;
    end

    // Walk state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walking_reg <= 1'b0;
            cur_ptr_reg <= '0;
            visited_reg <= '0;
            found_reg   <= '0;
            limit_reg   <= '0;
        end
        else if (accept)
        begin
            walking_reg <= walking_next;
            cur_ptr_reg <= cur_ptr_next;
            visited_reg <= visited_next;
            found_reg   <= found_next;
            limit_reg   <= limit_next;
        end
    end

    // Output buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (taken)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else if (!accept)
            begin
                out_valid_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg)
        begin
            out_valid_reg <= accept;
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output buffer payload
    always_ff @(posedge clk)
    begin
        if (taken)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (accept)
            begin
                out_reg <= res;
            end
        end
        else if (!out_valid_reg)
        begin
            if (accept)
            begin
                out_reg <= res;
            end
        end
        else if (accept)
        begin
            skid_reg <= res;
        end
    end

    // Skid entry only fills behind a held output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds an item while output register is empty");

    // A running walk always sits on an aligned pointer inside the window
    a_walk_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        walking_reg |-> (cur_ptr_reg >= pclw_pkg::CAP_LO && cur_ptr_reg[1:0] == 2'b00))
        else $error("walk pointer outside capability window");

    // Count never passes the step limit
    a_step_limit: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg <= pclw_pkg::COUNT_W'(pclw_pkg::MAX_STEPS))
        else $error("capability count beyond step limit");

    // A result that keeps the walk going names a header to read and carries ok
    a_continue: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.done_res) |->
            (out_reg.read_offset >= pclw_pkg::CAP_LO &&
             out_reg.result_status == pclw_pkg::ST_OK))
        else $error("continuing result without a valid read offset");

endmodule
